>>> design/kts_pkg.sv
// kts_pkg: shared types and codes of the keyframe track sampler
// request and result payloads, key value layout and mode codes
// no dependencies
package kts_pkg;

  // width of the key count register
  localparam int unsigned KeyCountW = 7;

  // mode codes of an input request
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // one input request
  typedef struct packed {
    logic               mode;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_value_x;
    logic signed [31:0] key_value_y;
    logic signed [31:0] key_value_z;
    logic [31:0]        sample_time;
  } in_req_t;

  // one result
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_res_t;

  // stored key value, three components
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } val_t;

endpackage

>>> design/kts_ram.sv
// kts_ram: generic single write port, single read port ram
// registered read data, no reset on the array
// no dependencies
module kts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/keyframe_track_sampler.sv
// keyframe_track_sampler: piecewise linear interpolation over a stored key track
// depends on kts_pkg and kts_ram (key time ram and key value ram)
//
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    in_req_i  (kts_pkg::in_req_t)
// out       out  out_valid_o / out_ready_i  out_res_o (kts_pkg::out_res_t)
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i (key count, 7 bits)
//
// a write request is accepted in S_IDLE, goes straight into both rams and the block stays ready
// a sample request scans the key time ram one key a cycle, then either fetches a key value
// (S_VRD, S_VCAP) or runs restoring division (value reads overlap) and a multiply and add
// for each component on the shared multiplier (S_MUL, S_ADD), then hands off in S_DONE
// reset sets the key count to 1; the rams are not cleared
// a new result waits in S_DONE while the last one is not taken by out_ready_i, writes wait meanwhile
module keyframe_track_sampler #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kts_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kts_pkg::out_res_t  out_res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);

  import kts_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_VRD  = 8'b0000_0100,
    S_VCAP = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_ADD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [KeyCountW-1:0] kc_q, kc_d;
  logic                 out_valid_q, out_valid_d;
  out_res_t             out_q, out_d;
  logic [31:0]          samp_q, samp_d;
  logic [CW-1:0]        last_q, last_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [31:0]          prev_q, prev_d;
  logic [AW-1:0]        vidx_q, vidx_d;
  logic [31:0]          rem_q, rem_d;
  logic [31:0]          den_q, den_d;
  logic                 zden_q, zden_d;
  logic [16:0]          quo_q, quo_d;
  logic [3:0]           dcnt_q, dcnt_d;
  val_t                 a_q, a_d, b_q, b_d;
  logic [1:0]           comp_q, comp_d;
  logic signed [50:0]   prod_q, prod_d;
  out_res_t             res_q, res_d;

  logic                 in_acc;
  logic                 wr_en;
  logic [AW-1:0]        t_raddr, v_raddr;
  logic [31:0]          t_rdata;
  logic [95:0]          v_rdata;
  val_t                 v_val;
  logic [32:0]          rem2;
  logic                 div_ge;
  logic [16:0]          frac;
  logic signed [31:0]   a_c, b_c;
  logic signed [32:0]   diff_s;
  logic signed [17:0]   frac_s;
  logic [31:0]          sum_c;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // key writes go straight into both rams
  assign wr_en = in_acc & (in_req_i.mode == MODE_WRITE) & (32'(in_req_i.key_index) < MAX_KEYS);

  kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(in_req_i.key_index)),
    .wdata_i (in_req_i.key_time),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  kts_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(in_req_i.key_index)),
    .wdata_i ({in_req_i.key_value_x, in_req_i.key_value_y, in_req_i.key_value_z}),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  assign v_val = val_t'(v_rdata);

  // read addresses
  always_comb begin
    t_raddr = '0;
    if (state_q == S_SCAN) begin
      t_raddr = AW'(idx_q + CW'(1));
    end
    v_raddr = vidx_q;
    if (state_q == S_DIV && dcnt_q != 4'd0) begin
      v_raddr = vidx_q + AW'(1);
    end
  end

  // shared divider step and multiplier datapath
  assign rem2   = {rem_q, 1'b0};
  assign div_ge = (rem2 >= {1'b0, den_q});
  assign frac   = zden_q ? 17'd0 : quo_q;

  always_comb begin
    case (comp_q)
      2'd0:    begin a_c = a_q.x; b_c = b_q.x; end
      2'd1:    begin a_c = a_q.y; b_c = b_q.y; end
      default: begin a_c = a_q.z; b_c = b_q.z; end
    endcase
  end

  assign diff_s = {b_c[31], b_c} - {a_c[31], a_c};
  assign frac_s = {1'b0, frac};
  assign sum_c  = a_c + prod_q[47:16];

  // sequencer
  always_comb begin
    state_d     = state_q;
    kc_d        = kc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    samp_d      = samp_q;
    last_d      = last_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    vidx_d      = vidx_q;
    rem_d       = rem_q;
    den_d       = den_q;
    zden_d      = zden_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    a_d         = a_q;
    b_d         = b_q;
    comp_d      = comp_q;
    prod_d      = prod_q;
    res_d       = res_q;

    // key count register
    if (cfg_valid_i) begin
      kc_d = cfg_data_i;
    end

    // result handoff
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && in_req_i.mode == MODE_SAMPLE) begin
          samp_d = in_req_i.sample_time;
          idx_d  = '0;
          if (kc_q == '0) begin
            last_d = '0;
          end else if (32'(kc_q) > MAX_KEYS) begin
            last_d = CW'(MAX_KEYS - 1);
          end else begin
            last_d = CW'(kc_q - KeyCountW'(1));
          end
          state_d = S_SCAN;
        end
      end
      // one key time per cycle, t_rdata holds key idx_q
      S_SCAN: begin
        if (idx_q == '0) begin
          if (last_q == '0 || samp_q <= t_rdata) begin
            vidx_d  = '0;
            state_d = S_VRD;
          end else begin
            prev_d = t_rdata;
            idx_d  = idx_q + CW'(1);
          end
        end else if (prev_q <= samp_q && samp_q <= t_rdata) begin
          // enclosing segment, top quotient bit set only when the time hits its end
          vidx_d  = AW'(idx_q - CW'(1));
          den_d   = t_rdata - prev_q;
          zden_d  = (t_rdata == prev_q);
          quo_d   = {16'd0, samp_q == t_rdata};
          rem_d   = (samp_q == t_rdata) ? 32'd0 : (samp_q - prev_q);
          dcnt_d  = '0;
          state_d = S_DIV;
        end else if (idx_q == last_q) begin
          vidx_d  = AW'(idx_q);
          state_d = S_VRD;
        end else begin
          prev_d = t_rdata;
          idx_d  = idx_q + CW'(1);
        end
      end
      S_VRD: begin
        state_d = S_VCAP;
      end
      S_VCAP: begin
        res_d   = {v_val.x, v_val.y, v_val.z};
        state_d = S_DONE;
      end
      // restoring division, one quotient bit a cycle; segment values read alongside
      S_DIV: begin
        rem_d  = div_ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
        quo_d  = {quo_q[15:0], div_ge};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd1) begin
          a_d = v_val;
        end
        if (dcnt_q == 4'd2) begin
          b_d = v_val;
        end
        if (dcnt_q == 4'd15) begin
          comp_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = diff_s * frac_s;
        state_d = S_ADD;
      end
      // floor of the product by 2^16 is its arithmetic shift
      S_ADD: begin
        case (comp_q)
          2'd0:    res_d.out_x = sum_c;
          2'd1:    res_d.out_y = sum_c;
          default: res_d.out_z = sum_c;
        endcase
        if (comp_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kc_q        <= KeyCountW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kc_q        <= kc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    samp_q <= samp_d;
    last_q <= last_d;
    idx_q  <= idx_d;
    prev_q <= prev_d;
    vidx_q <= vidx_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    zden_q <= zden_d;
    quo_q  <= quo_d;
    dcnt_q <= dcnt_d;
    a_q    <= a_d;
    b_q    <= b_d;
    comp_q <= comp_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

endmodule

>>> design/kts_checker.sv
// kts_checker: port level checks of the keyframe track sampler
// depends on kts_pkg; bound to keyframe_track_sampler below
module kts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input kts_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input kts_pkg::out_res_t out_res_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  import kts_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed or dropped");

  // a sample request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.mode == MODE_SAMPLE |=> !in_ready_o)
    else $error("ready after accepting a sample request");

  // a write request leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.mode == MODE_WRITE |=> in_ready_o)
    else $error("block busy after a write request");

  // a new result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a sample in progress");

  // the key count register never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (.*);
